>>> rtl/rbsfc_pkg.sv
// Shared types and constants of the ramp and brake state feedback controller.
// Used by the channel interfaces, the controller, the datapath and the top level.
package rbsfc_pkg;

  localparam int DATA_W_DEF = 32;
  localparam int FRAC_DEF   = 16;
  localparam int TICK_W     = 32;
  localparam int DUR_W      = 24;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_TICK,
    REG_CV_MAX,
    REG_RAMP_TICKS,
    REG_BRAKE_TICKS,
    REG_TARGET_POSITION,
    REG_GAIN_POSITION,
    REG_GAIN_VELOCITY,
    REG_DRIVE_OFFSET
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_BEFORE,
    PH_RAMP,
    PH_OPEN,
    PH_BRAKE,
    PH_HOLD
  } phase_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLASSIFY,
    OP_CV_ZERO,
    OP_MUL_RAMP,
    OP_MUL_BRKTEST,
    OP_MUL_VREF,
    OP_MUL_GPOS,
    OP_MUL_GVEL,
    OP_DIV_START,
    OP_CV_RAMP,
    OP_OPEN_DECIDE,
    OP_VREF_HOLDV,
    OP_VREF_DIV,
    OP_INTEGRATE,
    OP_HOLD_TARGET,
    OP_ACC_GPOS,
    OP_ACC_GVEL,
    OP_CV_CLOSED,
    OP_COMMIT
  } dp_op_t;

  typedef struct packed {
    logic   take;
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    phase_t phase;
    logic   brk_zero;
    logic   div_done;
    logic   out_busy;
  } dp_stat_t;

  function automatic int cfg_width(input int dw);
    return (dw > TICK_W) ? dw : TICK_W;
  endfunction

endpackage

>>> rtl/rbsfc_if.sv
// Valid/ready channel interfaces: sample input, result output and register writes.
// Depends on rbsfc_pkg for widths and the register index width.
interface rbsfc_in_if import rbsfc_pkg::*; #(
  parameter int DATA_WIDTH = DATA_W_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] measured_position;
  logic signed [DATA_WIDTH-1:0] measured_velocity;

  modport source (output valid, output measured_position, output measured_velocity,
                  input ready);
  modport sink (input valid, input measured_position, input measured_velocity,
                output ready);
endinterface

interface rbsfc_out_if import rbsfc_pkg::*; #(
  parameter int DATA_WIDTH = DATA_W_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] control_value;
  logic signed [DATA_WIDTH-1:0] position_reference;
  logic signed [DATA_WIDTH-1:0] velocity_reference;
  logic                         closed_loop_active;

  modport source (output valid, output control_value, output position_reference,
                  output velocity_reference, output closed_loop_active, input ready);
  modport sink (input valid, input control_value, input position_reference,
                input velocity_reference, input closed_loop_active, output ready);
endinterface

interface rbsfc_cfg_if import rbsfc_pkg::*; #(
  parameter int DATA_WIDTH = DATA_W_DEF
) ();
  localparam int CW = cfg_width(DATA_WIDTH);

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CW-1:0]        data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/rbsfc_div.sv
// Bit-serial restoring divider on unsigned magnitudes, one quotient bit per cycle.
// Stand-alone unit used by rbsfc_datapath; no package dependency.
module rbsfc_div #(
  parameter int DIVIDEND_W = 56,
  parameter int DIVISOR_W  = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic [DIVIDEND_W-1:0] quotient,
  output logic                  done
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_r;
  logic                  done_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVISOR_W-1:0]  dsr_r;
  logic [DIVIDEND_W-1:0] quo_r;
  logic [DIVISOR_W:0]    trial;
  logic                  fits;

  assign trial = {rem_r, quo_r[DIVIDEND_W-1]};
  assign fits  = (trial >= {1'b0, dsr_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(DIVIDEND_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? DIVISOR_W'(trial - {1'b0, dsr_r}) : trial[DIVISOR_W-1:0];
      quo_r <= {quo_r[DIVIDEND_W-2:0], fits};
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

>>> rtl/rbsfc_datapath.sv
// Datapath: configuration registers, controller state, shared multiplier, divider
// and result register. Depends on rbsfc_pkg, the channel interfaces and rbsfc_div.
module rbsfc_datapath import rbsfc_pkg::*; #(
  parameter int DATA_WIDTH = DATA_W_DEF,
  parameter int FRAC_BITS  = FRAC_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  rbsfc_in_if.sink     in_chan,
  rbsfc_out_if.source  out_chan,
  rbsfc_cfg_if.sink    cfg_chan,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat
);

  localparam int DW  = DATA_WIDTH;
  localparam int MB  = (DW + 1 > DUR_W + 1) ? DW + 1 : DUR_W + 1;
  localparam int PW  = DW + MB;
  localparam int SW  = PW + 4;
  localparam int DVW = DW + DUR_W;
  localparam logic signed [SW-1:0] SAT_HI = signed'({{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}});
  localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

  function automatic logic signed [DW-1:0] sat_dw(input logic signed [SW-1:0] x);
    if (x > SAT_HI) begin
      return SAT_HI[DW-1:0];
    end else if (x < SAT_LO) begin
      return SAT_LO[DW-1:0];
    end
    return x[DW-1:0];
  endfunction

  logic        [TICK_W-1:0] start_r;
  logic signed [DW-1:0]     cvmax_r;
  logic        [DUR_W-1:0]  ramp_r;
  logic        [DUR_W-1:0]  brk_r;
  logic signed [DW-1:0]     target_r;
  logic signed [DW-1:0]     gpos_r;
  logic signed [DW-1:0]     gvel_r;
  logic signed [DW-1:0]     offset_r;

  logic        [TICK_W-1:0] elapsed_r;
  logic                     closed_r;
  logic        [TICK_W-1:0] stop_r;
  logic signed [DW-1:0]     posref_r;
  logic signed [DW-1:0]     vprev_r;
  logic signed [DW-1:0]     vstop_r;

  logic signed [DW-1:0]     pos_r;
  logic signed [DW-1:0]     vel_r;
  logic signed [TICK_W:0]   t_r;
  logic signed [DW:0]       perr_r;
  logic signed [DW:0]       verr_r;
  phase_t                   phase_r;
  logic        [DUR_W-1:0]  fac_r;
  logic signed [PW-1:0]     prod_r;
  logic                     neg_r;
  logic signed [DW-1:0]     cv_r;
  logic signed [DW-1:0]     pref_r;
  logic signed [DW-1:0]     vref_r;
  logic signed [SW-1:0]     acc_r;

  logic                     out_valid_r;
  logic signed [DW-1:0]     ocv_r;
  logic signed [DW-1:0]     opref_r;
  logic signed [DW-1:0]     ovref_r;
  logic                     oclosed_r;

  logic signed [DW-1:0]     a_mux;
  logic signed [MB-1:0]     b_mux;
  logic signed [TICK_W+1:0] t_x;
  logic signed [TICK_W+1:0] stop_end;
  logic signed [TICK_W+1:0] d_x;
  phase_t                   phase_nxt;
  logic        [DUR_W-1:0]  fac_nxt;
  logic signed [PW-1:0]     prod_mag;
  logic        [DVW-1:0]    quo;
  logic                     div_done;
  logic signed [SW-1:0]     q_ext;
  logic signed [SW-1:0]     q_sgn;
  logic signed [DW-1:0]     q_sat;
  logic                     close_now;
  logic signed [SW-1:0]     integ_sum;
  logic signed [DW-1:0]     integ_sat;

  always_comb begin
    t_x      = (TICK_W+2)'(t_r);
    stop_end = signed'((TICK_W+2)'(stop_r) + (TICK_W+2)'(brk_r));
    d_x      = t_x - signed'((TICK_W+2)'(stop_r));
    priority if (t_r[TICK_W]) begin
      phase_nxt = PH_BEFORE;
    end else if (t_r < signed'((TICK_W+1)'(ramp_r))) begin
      phase_nxt = PH_RAMP;
    end else if (!closed_r) begin
      phase_nxt = PH_OPEN;
    end else if (t_x > stop_end) begin
      phase_nxt = PH_HOLD;
    end else begin
      phase_nxt = PH_BRAKE;
    end
    fac_nxt = d_x[TICK_W+1] ? brk_r : brk_r - d_x[DUR_W-1:0];
  end

  always_comb begin
    unique case (cmd.op)
      OP_MUL_RAMP: begin
        a_mux = cvmax_r;
        b_mux = signed'(MB'({1'b0, t_r[DUR_W-1:0]}));
      end
      OP_MUL_BRKTEST: begin
        a_mux = vel_r;
        b_mux = signed'(MB'(brk_r));
      end
      OP_MUL_VREF: begin
        a_mux = vstop_r;
        b_mux = signed'(MB'(fac_r));
      end
      OP_MUL_GPOS: begin
        a_mux = gpos_r;
        b_mux = MB'(perr_r);
      end
      default: begin
        a_mux = gvel_r;
        b_mux = MB'(verr_r);
      end
    endcase
  end

  assign prod_mag = prod_r[PW-1] ? -prod_r : prod_r;

  rbsfc_div #(
    .DIVIDEND_W (DVW),
    .DIVISOR_W  (DUR_W)
  ) u_rbsfc_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.op == OP_DIV_START),
    .dividend (prod_mag[DVW-1:0]),
    .divisor  ((phase_r == PH_RAMP) ? ramp_r : brk_r),
    .quotient (quo),
    .done     (div_done)
  );

  assign q_ext = signed'(SW'(quo));
  assign q_sgn = neg_r ? -q_ext : q_ext;
  assign q_sat = sat_dw(q_sgn);

  assign close_now = (SW'(target_r) <<< 1) < ((SW'(pos_r) <<< 1) + SW'(prod_r));

  assign integ_sum = ((SW'(posref_r) <<< 1) + (SW'(vref_r) <<< 1) + SW'(vref_r)
                      - SW'(vprev_r)) >>> 1;
  assign integ_sat = sat_dw(integ_sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r     <= '0;
      cvmax_r     <= '0;
      ramp_r      <= '0;
      brk_r       <= '0;
      target_r    <= '0;
      gpos_r      <= '0;
      gvel_r      <= '0;
      offset_r    <= '0;
      elapsed_r   <= '0;
      closed_r    <= 1'b0;
      stop_r      <= '0;
      posref_r    <= '0;
      vprev_r     <= '0;
      vstop_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_chan.valid) begin
        unique case (cfg_reg_t'(cfg_chan.index))
          REG_START_TICK:      start_r  <= cfg_chan.data[TICK_W-1:0];
          REG_CV_MAX:          cvmax_r  <= signed'(cfg_chan.data[DW-1:0]);
          REG_RAMP_TICKS:      ramp_r   <= cfg_chan.data[DUR_W-1:0];
          REG_BRAKE_TICKS:     brk_r    <= cfg_chan.data[DUR_W-1:0];
          REG_TARGET_POSITION: target_r <= signed'(cfg_chan.data[DW-1:0]);
          REG_GAIN_POSITION:   gpos_r   <= signed'(cfg_chan.data[DW-1:0]);
          REG_GAIN_VELOCITY:   gvel_r   <= signed'(cfg_chan.data[DW-1:0]);
          REG_DRIVE_OFFSET:    offset_r <= signed'(cfg_chan.data[DW-1:0]);
        endcase
      end
      if (cmd.op == OP_OPEN_DECIDE && close_now) begin
        closed_r <= 1'b1;
        stop_r   <= t_r[TICK_W-1:0];
        vstop_r  <= vel_r;
        vprev_r  <= vel_r;
        posref_r <= pos_r;
      end
      if (cmd.op == OP_INTEGRATE) begin
        posref_r <= integ_sat;
        vprev_r  <= vref_r;
      end
      if (cmd.op == OP_COMMIT) begin
        out_valid_r <= 1'b1;
        if (elapsed_r != '1) begin
          elapsed_r <= elapsed_r + TICK_W'(1);
        end
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && in_chan.valid) begin
      pos_r  <= in_chan.measured_position;
      vel_r  <= in_chan.measured_velocity;
      t_r    <= signed'({1'b0, elapsed_r}) - signed'({1'b0, start_r});
      perr_r <= (DW+1)'(target_r) - (DW+1)'(in_chan.measured_position);
    end
    unique case (cmd.op)
      OP_CLASSIFY: begin
        phase_r <= phase_nxt;
        fac_r   <= fac_nxt;
      end
      OP_CV_ZERO: begin
        cv_r   <= '0;
        pref_r <= pos_r;
        vref_r <= '0;
      end
      OP_MUL_RAMP, OP_MUL_BRKTEST, OP_MUL_VREF, OP_MUL_GPOS, OP_MUL_GVEL: begin
        prod_r <= a_mux * b_mux;
      end
      OP_DIV_START: neg_r <= prod_r[PW-1];
      OP_CV_RAMP: begin
        cv_r   <= q_sat;
        pref_r <= pos_r;
        vref_r <= '0;
      end
      OP_OPEN_DECIDE: begin
        cv_r   <= cvmax_r;
        pref_r <= pos_r;
        vref_r <= close_now ? vel_r : '0;
      end
      OP_VREF_HOLDV: vref_r <= vstop_r;
      OP_VREF_DIV:   vref_r <= q_sat;
      OP_INTEGRATE:  pref_r <= posref_r;
      OP_HOLD_TARGET: begin
        pref_r <= target_r;
        vref_r <= '0;
      end
      OP_ACC_GPOS: begin
        acc_r  <= SW'(offset_r) + (SW'(prod_r) >>> FRAC_BITS);
        verr_r <= (DW+1)'(vref_r) - (DW+1)'(vel_r);
      end
      OP_ACC_GVEL:  acc_r <= acc_r + (SW'(prod_r) >>> FRAC_BITS);
      OP_CV_CLOSED: cv_r  <= sat_dw(acc_r);
      OP_COMMIT: begin
        ocv_r     <= cv_r;
        opref_r   <= pref_r;
        ovref_r   <= vref_r;
        oclosed_r <= closed_r;
      end
      default: ;
    endcase
  end

  assign in_chan.ready  = cmd.take;
  assign cfg_chan.ready = 1'b1;

  assign out_chan.valid              = out_valid_r;
  assign out_chan.control_value      = ocv_r;
  assign out_chan.position_reference = opref_r;
  assign out_chan.velocity_reference = ovref_r;
  assign out_chan.closed_loop_active = oclosed_r;

  assign stat.phase    = phase_r;
  assign stat.brk_zero = (brk_r == '0);
  assign stat.div_done = div_done;
  assign stat.out_busy = out_valid_r & ~out_chan.ready;

endmodule

>>> rtl/rbsfc_ctrl.sv
// Sequencer that steps the datapath through one sample word at a time.
// Depends on rbsfc_pkg for the command and status structures.
module rbsfc_ctrl import rbsfc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLASS,
    S_BRANCH,
    S_DIV_MUL,
    S_DIV_KICK,
    S_DIV_WAIT,
    S_OPEN_DEC,
    S_INTEG,
    S_GPOS,
    S_GPOS_ACC,
    S_GVEL,
    S_GVEL_ACC,
    S_CVC,
    S_FINISH,
    S_COMMIT
  } state_t;

  state_t  state_r;
  dp_cmd_t cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cmd_r.take <= 1'b1;
      cmd_r.op   <= OP_NONE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r    <= S_CLASS;
            cmd_r.take <= 1'b0;
            cmd_r.op   <= OP_CLASSIFY;
          end
        end
        S_CLASS: begin
          state_r  <= S_BRANCH;
          cmd_r.op <= OP_NONE;
        end
        S_BRANCH: begin
          unique case (stat.phase)
            PH_BEFORE: begin
              state_r  <= S_FINISH;
              cmd_r.op <= OP_CV_ZERO;
            end
            PH_RAMP: begin
              state_r  <= S_DIV_MUL;
              cmd_r.op <= OP_MUL_RAMP;
            end
            PH_OPEN: begin
              state_r  <= S_OPEN_DEC;
              cmd_r.op <= OP_MUL_BRKTEST;
            end
            PH_BRAKE: begin
              if (stat.brk_zero) begin
                state_r  <= S_INTEG;
                cmd_r.op <= OP_VREF_HOLDV;
              end else begin
                state_r  <= S_DIV_MUL;
                cmd_r.op <= OP_MUL_VREF;
              end
            end
            PH_HOLD: begin
              state_r  <= S_GPOS;
              cmd_r.op <= OP_HOLD_TARGET;
            end
            default: begin
              state_r  <= S_FINISH;
              cmd_r.op <= OP_CV_ZERO;
            end
          endcase
        end
        S_DIV_MUL: begin
          state_r  <= S_DIV_KICK;
          cmd_r.op <= OP_DIV_START;
        end
        S_DIV_KICK: begin
          state_r  <= S_DIV_WAIT;
          cmd_r.op <= OP_NONE;
        end
        S_DIV_WAIT: begin
          if (stat.div_done) begin
            if (stat.phase == PH_RAMP) begin
              state_r  <= S_FINISH;
              cmd_r.op <= OP_CV_RAMP;
            end else begin
              state_r  <= S_INTEG;
              cmd_r.op <= OP_VREF_DIV;
            end
          end
        end
        S_OPEN_DEC: begin
          state_r  <= S_FINISH;
          cmd_r.op <= OP_OPEN_DECIDE;
        end
        S_INTEG: begin
          state_r  <= S_GPOS;
          cmd_r.op <= OP_INTEGRATE;
        end
        S_GPOS: begin
          state_r  <= S_GPOS_ACC;
          cmd_r.op <= OP_MUL_GPOS;
        end
        S_GPOS_ACC: begin
          state_r  <= S_GVEL;
          cmd_r.op <= OP_ACC_GPOS;
        end
        S_GVEL: begin
          state_r  <= S_GVEL_ACC;
          cmd_r.op <= OP_MUL_GVEL;
        end
        S_GVEL_ACC: begin
          state_r  <= S_CVC;
          cmd_r.op <= OP_ACC_GVEL;
        end
        S_CVC: begin
          state_r  <= S_FINISH;
          cmd_r.op <= OP_CV_CLOSED;
        end
        S_FINISH: begin
          if (!stat.out_busy) begin
            state_r  <= S_COMMIT;
            cmd_r.op <= OP_COMMIT;
          end else begin
            cmd_r.op <= OP_NONE;
          end
        end
        S_COMMIT: begin
          state_r    <= S_IDLE;
          cmd_r.take <= 1'b1;
          cmd_r.op   <= OP_NONE;
        end
        default: begin
          state_r    <= S_IDLE;
          cmd_r.take <= 1'b1;
          cmd_r.op   <= OP_NONE;
        end
      endcase
    end
  end

  assign cmd = cmd_r;

endmodule

>>> rtl/ramp_brake_state_feedback_ctrl_top.sv
// Top level of the ramp and brake state feedback controller.
// Depends on rbsfc_pkg, the channel interfaces, rbsfc_ctrl and rbsfc_datapath.

// One sample word in gives one result word out. Words are handled one at a time, and the
// time between accepting one sample word and accepting the next depends on the phase. A
// word in the ramp or in the braking decay waits on the bit-serial divider, which runs
// DATA_WIDTH + 24 steps; words in the other phases, and braking words with a zero brake
// length, need no division.
// Results sit in an output register, so the next sample word is taken while a result still
// waits; that word is then held just before its commit for as long as the result stalls.
// Registers are written through the configuration channel, which is always ready,
// and should only be written while no sample word is being processed.
module ramp_brake_state_feedback_ctrl_top import rbsfc_pkg::*; #(
  parameter int DATA_WIDTH = DATA_W_DEF,
  parameter int FRAC_BITS  = FRAC_DEF
) (
  input logic clk,
  input logic rst_n,
  rbsfc_in_if.sink    in_chan,
  rbsfc_out_if.source out_chan,
  rbsfc_cfg_if.sink   cfg_chan
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rbsfc_ctrl u_rbsfc_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .stat     (stat),
    .cmd      (cmd)
  );

  rbsfc_datapath #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_rbsfc_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

>>> rtl/rbsfc_checker.sv
// Port-level checks of the controller top level over time, and their binding.
// Depends on rbsfc_pkg and ramp_brake_state_feedback_ctrl_top.
module rbsfc_checker import rbsfc_pkg::*; #(
  parameter int DATA_WIDTH = DATA_W_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [DATA_WIDTH-1:0] control_value,
  input logic [DATA_WIDTH-1:0] position_reference,
  input logic [DATA_WIDTH-1:0] velocity_reference,
  input logic                  closed_loop_active
);

  logic [1:0] pending_r;
  logic       seen_closed_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid & in_ready;
  assign out_acc = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r     <= '0;
      seen_closed_r <= 1'b0;
    end else begin
      pending_r <= pending_r + 2'(in_acc) - 2'(out_acc);
      if (out_acc && closed_loop_active) begin
        seen_closed_r <= 1'b1;
      end
    end
  end

  // A result word that is not taken holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(control_value)
      && $stable(position_reference) && $stable(velocity_reference)
      && $stable(closed_loop_active))
    else $error("result word changed while stalled");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Every result belongs to a sample word, and only one word waits behind a result.
  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid |-> pending_r != 2'd0) and (in_acc |-> pending_r <= 2'd1))
    else $error("result words and sample words out of step");

  a_closed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_closed_r |-> closed_loop_active)
    else $error("closed loop flag fell");

  a_open_vref: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !closed_loop_active |-> velocity_reference == '0)
    else $error("velocity reference set in open loop");

endmodule

bind ramp_brake_state_feedback_ctrl_top rbsfc_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_rbsfc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_chan.valid),
  .in_ready           (in_chan.ready),
  .out_valid          (out_chan.valid),
  .out_ready          (out_chan.ready),
  .control_value      (out_chan.control_value),
  .position_reference (out_chan.position_reference),
  .velocity_reference (out_chan.velocity_reference),
  .closed_loop_active (out_chan.closed_loop_active)
);
